### rtl/core/bmls_pkg.sv
package bmls_pkg;

   localparam int BMLS_NUM_BINS = 256;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_MIN_POSITION   = 3'd0,
      CSR_BIN_WIDTH      = 3'd1,
      CSR_BINS_IN_USE    = 3'd2,
      CSR_MIN_SAMPLES    = 3'd3,
      CSR_SAFETY_MARGIN  = 3'd4,
      CSR_ERROR_THRESH   = 3'd5,
      CSR_DEFAULT_MAX_V  = 3'd6,
      CSR_DEFAULT_MAX_A  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   localparam logic [1:0] REASON_NO_DATA = 2'd0;
   localparam logic [1:0] REASON_ERROR   = 2'd1;
   localparam logic [1:0] REASON_PERF    = 2'd2;

   localparam logic signed [31:0] RST_MIN_POSITION  = 32'sd0;
   localparam logic [23:0]        RST_BIN_WIDTH     = 24'd1024;
   localparam logic [8:0]         RST_BINS_IN_USE   = 9'd256;
   localparam logic [15:0]        RST_MIN_SAMPLES   = 16'd10;
   localparam logic [15:0]        RST_SAFETY_MARGIN = 16'd6554;
   localparam logic [31:0]        RST_ERROR_THRESH  = 32'd10000;
   localparam logic [31:0]        RST_DEFAULT_MAX_V = 32'd10000000;
   localparam logic [31:0]        RST_DEFAULT_MAX_A = 32'd1000000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] position;
      logic [31:0]        velocity;
      logic [31:0]        accel;
      logic [31:0]        tracking_error;
      logic [17:0]        feed_ratio;
   } req_type;

   typedef struct packed {
      logic [31:0] suggested_velocity;
      logic [31:0] suggested_accel;
      logic [1:0]  limit_reason;
      logic [31:0] bin_samples;
      logic [31:0] bin_max_velocity;
      logic [31:0] bin_max_accel;
      logic [31:0] bin_max_error;
      logic [47:0] bin_mean_error;
      logic [17:0] bin_mean_ratio;
   } rsp_type;

   typedef struct packed {
      logic [31:0] count;
      logic [31:0] max_v;
      logic [31:0] max_a;
      logic [31:0] max_e;
      logic [47:0] mean_e;
      logic [17:0] mean_r;
   } stat_type;

endpackage

### rtl/core/binned_motion_limit_stats.sv
// an add holds the block through the bin divide, read, mean divides and write, and a clear
//   through a pass over all NUM_BINS entries; with no bins in use a request skips the divide
// throughput: one request at a time; a shared restoring divider (one quotient bit per
//   cycle) runs 32 steps for the bin, 48 + 18 for the means, 17 for the error factor
// reset: synchronous; afterwards a clearing pass over all NUM_BINS entries zeroes the
//   statistics memory, during which no request is taken
module binned_motion_limit_stats
   import bmls_pkg::*;
#(
   parameter int NUM_BINS = BMLS_NUM_BINS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_addr,
   input  logic [31:0]   csr_wdata
);

   localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CW = $clog2(NUM_BINS + 1);

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_CLEAR   = 16'h0002,
      S_BIN     = 16'h0004,
      S_READ    = 16'h0008,
      S_LOAD    = 16'h0010,
      S_DIV_ERR = 16'h0020,
      S_DIV_RAT = 16'h0040,
      S_WRITE   = 16'h0080,
      S_MUL_V   = 16'h0100,
      S_MUL_A   = 16'h0200,
      S_CHK     = 16'h0400,
      S_DIV_F   = 16'h0800,
      S_SCL_V   = 16'h1000,
      S_SCL_A   = 16'h2000,
      S_SCL_W   = 16'h4000,
      S_OUT     = 16'h8000
   } state_type;

   // configuration
   logic signed [31:0] cfg_min_ff;
   logic [23:0]        cfg_width_ff;
   logic [8:0]         cfg_bins_ff;
   logic [15:0]        cfg_minsmp_ff;
   logic [15:0]        cfg_margin_ff;
   logic [31:0]        cfg_thr_ff;
   logic [31:0]        cfg_defv_ff;
   logic [31:0]        cfg_defa_ff;

   state_type         state_ff, state_in;
   logic [BW-1:0]     clr_ff, clr_in;
   req_type           req_ff, req_in;
   logic [BW-1:0]     bin_ff, bin_in;
   stat_type          ent_ff, ent_in;
   stat_type          rd_ff;
   logic [1:0]        sgn_ff, sgn_in;
   logic [31:0]       v_ff, v_in;
   logic [31:0]       a_ff, a_in;
   logic [1:0]        reason_ff, reason_in;
   logic [16:0]       f_ff, f_in;
   logic [48:0]       prod_ff;
   logic [47:0]       div_rem_ff, div_rem_in;
   logic [63:0]       div_quo_ff, div_quo_in;
   logic [47:0]       div_den_ff, div_den_in;
   logic [6:0]        div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   stat_type          mem [NUM_BINS];
   logic [BW-1:0]     mem_addr;
   logic              mem_we;
   stat_type          mem_wdata;

   logic [31:0]       mul_a;
   logic [16:0]       mul_b;

   logic [CW-1:0]     used_w;
   logic              used_zero;
   logic [23:0]       width_eff;
   logic [32:0]       pos_diff;
   logic [48:0]       div_t;
   logic [48:0]       div_sub;
   logic              div_ge;
   logic [31:0]       count_next;
   logic [47:0]       x_err;
   logic [16:0]       m_fac;
   logic [16:0]       f_raw;
   logic [31:0]       out_v;
   logic [31:0]       out_a;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign used_w    = (32'(cfg_bins_ff) > 32'(NUM_BINS)) ? CW'(NUM_BINS) : CW'(cfg_bins_ff);
   assign used_zero = (used_w == '0);
   assign width_eff = (cfg_width_ff == '0) ? 24'd1 : cfg_width_ff;
   assign pos_diff  = {req_data.position[31], req_data.position} - {cfg_min_ff[31], cfg_min_ff};

   // one restoring divide step
   assign div_t   = {div_rem_ff, div_quo_ff[63]};
   assign div_sub = div_t - {1'b0, div_den_ff};
   assign div_ge  = !div_sub[48];

   assign count_next = (rd_ff.count == 32'hFFFF_FFFF) ? rd_ff.count : rd_ff.count + 32'd1;
   assign x_err      = {req_ff.tracking_error, 16'b0};
   assign m_fac      = 17'h1_0000 - {1'b0, cfg_margin_ff};
   assign f_raw      = div_quo_ff[16:0];
   assign out_v      = (v_ff > cfg_defv_ff) ? cfg_defv_ff : v_ff;
   assign out_a      = (a_ff > cfg_defa_ff) ? cfg_defa_ff : a_ff;

   always_comb begin
      mul_a = a_ff;
      mul_b = f_ff;
      unique case (state_ff)
         S_MUL_V: begin
            mul_a = ent_ff.max_v;
            mul_b = m_fac;
         end
         S_MUL_A: begin
            mul_a = ent_ff.max_a;
            mul_b = m_fac;
         end
         S_SCL_V: begin
            mul_a = v_ff;
         end
         default: begin
            mul_a = a_ff;
         end
      endcase
   end

   always_comb begin
      mem_addr  = (state_ff == S_CLEAR) ? clr_ff : bin_ff;
      mem_we    = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
      mem_wdata = (state_ff == S_CLEAR) ? '0 : ent_ff;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      bin_in       = bin_ff;
      ent_in       = ent_ff;
      sgn_in       = sgn_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      reason_in    = reason_ff;
      f_in         = f_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? div_sub[47:0] : div_t[47:0];
         div_quo_in = {div_quo_ff[62:0], div_ge};
         div_cnt_in = div_cnt_ff - 7'd1;
      end else begin
         div_rem_in = div_rem_ff;
         div_quo_in = div_quo_ff;
         div_cnt_in = div_cnt_ff;
      end
      div_den_in = div_den_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               unique case (command_type'(req_data.command))
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_ADD, CMD_QUERY: begin
                     if (used_zero) begin
                        ent_in    = '0;
                        v_in      = cfg_defv_ff;
                        a_in      = cfg_defa_ff;
                        reason_in = REASON_NO_DATA;
                        state_in  = (req_data.command == CMD_QUERY) ? S_OUT : S_IDLE;
                     end else begin
                        // position below range divides zero
                        div_rem_in = '0;
                        div_quo_in = {(pos_diff[32] ? 32'd0 : pos_diff[31:0]), 32'd0};
                        div_den_in = {24'd0, width_eff};
                        div_cnt_in = 7'd32;
                        state_in   = S_BIN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BW'(NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_BIN: begin
            if (div_cnt_ff == '0) begin
               bin_in   = (div_quo_ff[31:0] >= 32'(used_w)) ? BW'(used_w - 1'b1)
                                                            : div_quo_ff[BW-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (req_ff.command == CMD_ADD) begin
               ent_in.count  = count_next;
               ent_in.max_v  = (req_ff.velocity > rd_ff.max_v) ? req_ff.velocity : rd_ff.max_v;
               ent_in.max_a  = (req_ff.accel > rd_ff.max_a) ? req_ff.accel : rd_ff.max_a;
               ent_in.max_e  = (req_ff.tracking_error > rd_ff.max_e) ? req_ff.tracking_error
                                                                      : rd_ff.max_e;
               ent_in.mean_e = rd_ff.mean_e;
               ent_in.mean_r = rd_ff.mean_r;
               sgn_in[0]     = (x_err >= rd_ff.mean_e);
               div_rem_in    = '0;
               div_quo_in    = {((x_err >= rd_ff.mean_e) ? x_err - rd_ff.mean_e
                                                         : rd_ff.mean_e - x_err), 16'd0};
               div_den_in    = {16'd0, count_next};
               div_cnt_in    = 7'd48;
               state_in      = S_DIV_ERR;
            end else begin
               ent_in = rd_ff;
               if (rd_ff.count < 32'(cfg_minsmp_ff)) begin
                  v_in      = cfg_defv_ff;
                  a_in      = cfg_defa_ff;
                  reason_in = REASON_NO_DATA;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_MUL_V;
               end
            end
         end
         S_DIV_ERR: begin
            if (div_cnt_ff == '0) begin
               ent_in.mean_e = sgn_ff[0] ? ent_ff.mean_e + div_quo_ff[47:0]
                                         : ent_ff.mean_e - div_quo_ff[47:0];
               sgn_in[1]     = (req_ff.feed_ratio >= ent_ff.mean_r);
               div_rem_in    = '0;
               div_quo_in    = {((req_ff.feed_ratio >= ent_ff.mean_r)
                                 ? req_ff.feed_ratio - ent_ff.mean_r
                                 : ent_ff.mean_r - req_ff.feed_ratio), 46'd0};
               div_cnt_in    = 7'd18;
               state_in      = S_DIV_RAT;
            end
         end
         S_DIV_RAT: begin
            if (div_cnt_ff == '0) begin
               ent_in.mean_r = sgn_ff[1] ? ent_ff.mean_r + div_quo_ff[17:0]
                                         : ent_ff.mean_r - div_quo_ff[17:0];
               state_in      = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         S_MUL_V: begin
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            v_in     = prod_ff[47:16];
            state_in = S_CHK;
         end
         S_CHK: begin
            a_in = prod_ff[47:16];
            if (ent_ff.mean_e > {cfg_thr_ff, 16'd0}) begin
               // quotient stays below 2^17, so the upper steps are skipped
               reason_in  = REASON_ERROR;
               div_rem_in = {1'b0, cfg_thr_ff, 15'd0};
               div_quo_in = '0;
               div_den_in = ent_ff.mean_e;
               div_cnt_in = 7'd17;
               state_in   = S_DIV_F;
            end else begin
               reason_in = REASON_PERF;
               state_in  = S_OUT;
            end
         end
         S_DIV_F: begin
            if (div_cnt_ff == '0) begin
               f_in     = (f_raw < 17'h0_8000) ? 17'h0_8000
                        : ((f_raw > 17'h1_0000) ? 17'h1_0000 : f_raw);
               state_in = S_SCL_V;
            end
         end
         S_SCL_V: begin
            state_in = S_SCL_A;
         end
         S_SCL_A: begin
            v_in     = prod_ff[47:16];
            state_in = S_SCL_W;
         end
         S_SCL_W: begin
            a_in     = prod_ff[47:16];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.suggested_velocity = out_v;
               rsp_data_in.suggested_accel    = out_a;
               rsp_data_in.limit_reason       = reason_ff;
               rsp_data_in.bin_samples        = ent_ff.count;
               rsp_data_in.bin_max_velocity   = ent_ff.max_v;
               rsp_data_in.bin_max_accel      = ent_ff.max_a;
               rsp_data_in.bin_max_error      = ent_ff.max_e;
               rsp_data_in.bin_mean_error     = ent_ff.mean_e;
               rsp_data_in.bin_mean_ratio     = ent_ff.mean_r;
               state_in                       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      req_ff      <= req_in;
      bin_ff      <= bin_in;
      ent_ff      <= ent_in;
      sgn_ff      <= sgn_in;
      v_ff        <= v_in;
      a_ff        <= a_in;
      reason_ff   <= reason_in;
      f_ff        <= f_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_ff    <= RST_MIN_POSITION;
         cfg_width_ff  <= RST_BIN_WIDTH;
         cfg_bins_ff   <= RST_BINS_IN_USE;
         cfg_minsmp_ff <= RST_MIN_SAMPLES;
         cfg_margin_ff <= RST_SAFETY_MARGIN;
         cfg_thr_ff    <= RST_ERROR_THRESH;
         cfg_defv_ff   <= RST_DEFAULT_MAX_V;
         cfg_defa_ff   <= RST_DEFAULT_MAX_A;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_POSITION:  cfg_min_ff    <= csr_wdata;
            CSR_BIN_WIDTH:     cfg_width_ff  <= csr_wdata[23:0];
            CSR_BINS_IN_USE:   cfg_bins_ff   <= csr_wdata[8:0];
            CSR_MIN_SAMPLES:   cfg_minsmp_ff <= csr_wdata[15:0];
            CSR_SAFETY_MARGIN: cfg_margin_ff <= csr_wdata[15:0];
            CSR_ERROR_THRESH:  cfg_thr_ff    <= csr_wdata;
            CSR_DEFAULT_MAX_V: cfg_defv_ff   <= csr_wdata;
            CSR_DEFAULT_MAX_A: cfg_defa_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

### rtl/core/bmls_checker.sv
module bmls_checker
   import bmls_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // clearing pass follows reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // queries and clears keep the block busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_data.command == CMD_QUERY || req_data.command == CMD_CLEAR)) |=> !req_ready)
      else $error("ready right after a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   a_reason_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.limit_reason != 2'd3))
      else $error("bad limit reason");

endmodule

bind binned_motion_limit_stats bmls_checker u_bmls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/binned_motion_limit_stats_tb.sv
`timescale 1ns / 1ps

module binned_motion_limit_stats_tb;
   import bmls_pkg::*;

   localparam int NBINS = BMLS_NUM_BINS;
   localparam int WATCHDOG_LIMIT = 20000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_addr = CSR_MIN_POSITION;
   logic [31:0]   csr_wdata = '0;

   binned_motion_limit_stats dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers
   logic signed [31:0] cfg_min_pos;
   logic [23:0]        cfg_width;
   logic [8:0]         cfg_bins;
   logic [15:0]        cfg_min_samples;
   logic [15:0]        cfg_margin;
   logic [31:0]        cfg_err_thresh;
   logic [31:0]        cfg_def_v;
   logic [31:0]        cfg_def_a;

   stat_type bin_stats[NBINS];
   rsp_type  expected_limits[$];

   int  fail_count = 0;
   int  query_count = 0;
   int  add_count = 0;
   int  idle_pct = 21;
   bit  rsp_hold = 1'b0;
   int  quiet_cycles = 0;

   function automatic int bin_of(logic signed [31:0] pos, int used);
      logic signed [33:0] d;
      logic [33:0]        q;
      logic [23:0]        w;
      begin
         d = 34'(pos) - 34'(cfg_min_pos);
         w = (cfg_width == 0) ? 24'd1 : cfg_width;
         if (d < 0) return 0;
         q = d / w;
         return (q >= used) ? used - 1 : int'(q);
      end
   endfunction

   function automatic logic [47:0] mean_step(logic [47:0] mean, logic [47:0] x,
                                             logic [31:0] n);
      begin
         if (x >= mean) return mean + (x - mean) / n;
         return mean - (mean - x) / n;
      end
   endfunction

   function automatic int bins_used();
      return (cfg_bins > NBINS) ? NBINS : int'(cfg_bins);
   endfunction

   function automatic void clear_stats();
      foreach (bin_stats[i]) bin_stats[i] = '0;
   endfunction

   task automatic predict_request(req_type r);
      int       used;
      int       b;
      rsp_type  e;
      logic [63:0] v, a, m, f, me;
      begin
         used = bins_used();
         e = '0;
         case (command_type'(r.command))
            CMD_CLEAR: clear_stats();
            CMD_ADD: if (used != 0) begin
               b = bin_of(r.position, used);
               if (bin_stats[b].count != 32'hFFFF_FFFF)
                  bin_stats[b].count++;
               if (r.velocity > bin_stats[b].max_v) bin_stats[b].max_v = r.velocity;
               if (r.accel > bin_stats[b].max_a) bin_stats[b].max_a = r.accel;
               if (r.tracking_error > bin_stats[b].max_e)
                  bin_stats[b].max_e = r.tracking_error;
               bin_stats[b].mean_e = mean_step(bin_stats[b].mean_e,
                  {r.tracking_error, 16'h0}, bin_stats[b].count);
               bin_stats[b].mean_r = 18'(mean_step(48'(bin_stats[b].mean_r),
                  48'(r.feed_ratio), bin_stats[b].count));
            end
            CMD_QUERY: begin
               if (used == 0) begin
                  e.suggested_velocity = cfg_def_v;
                  e.suggested_accel = cfg_def_a;
                  e.limit_reason = REASON_NO_DATA;
               end else begin
                  b = bin_of(r.position, used);
                  if (bin_stats[b].count < cfg_min_samples) begin
                     v = cfg_def_v;
                     a = cfg_def_a;
                     e.limit_reason = REASON_NO_DATA;
                  end else begin
                     m = 64'd65536 - cfg_margin;
                     me = bin_stats[b].mean_e;
                     v = (64'(bin_stats[b].max_v) * m) >> 16;
                     a = (64'(bin_stats[b].max_a) * m) >> 16;
                     if (me > (64'(cfg_err_thresh) << 16)) begin
                        f = (64'(cfg_err_thresh) << 32) / me;
                        if (f < 32768) f = 32768;
                        if (f > 65536) f = 65536;
                        v = (v * f) >> 16;
                        a = (a * f) >> 16;
                        e.limit_reason = REASON_ERROR;
                     end else begin
                        e.limit_reason = REASON_PERF;
                     end
                     if (v > cfg_def_v) v = cfg_def_v;
                     if (a > cfg_def_a) a = cfg_def_a;
                  end
                  e.suggested_velocity = v[31:0];
                  e.suggested_accel = a[31:0];
                  e.bin_samples = bin_stats[b].count;
                  e.bin_max_velocity = bin_stats[b].max_v;
                  e.bin_max_accel = bin_stats[b].max_a;
                  e.bin_max_error = bin_stats[b].max_e;
                  e.bin_mean_error = bin_stats[b].mean_e;
                  e.bin_mean_ratio = bin_stats[b].mean_r;
               end
               expected_limits = {expected_limits, e};
            end
            default: ;
         endcase
      end
   endtask

   // valid stays up after the accept until the next idle cycle or drain lowers it
   task automatic send_request(req_type r);
      begin
         while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= r;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         predict_request(r);
         if (r.command == CMD_ADD) add_count++;
         if (r.command == CMD_QUERY) query_count++;
         @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= val;
         @(negedge clock);
         csr_we <= 1'b0;
         case (idx)
            CSR_MIN_POSITION:  cfg_min_pos = val;
            CSR_BIN_WIDTH:     cfg_width = val[23:0];
            CSR_BINS_IN_USE:   cfg_bins = val[8:0];
            CSR_MIN_SAMPLES:   cfg_min_samples = val[15:0];
            CSR_SAFETY_MARGIN: cfg_margin = val[15:0];
            CSR_ERROR_THRESH:  cfg_err_thresh = val;
            CSR_DEFAULT_MAX_V: cfg_def_v = val;
            CSR_DEFAULT_MAX_A: cfg_def_a = val;
            default: ;
         endcase
      end
   endtask

   // adds and clears give no response, so allow the longest add or clear to finish
   task automatic drain();
      begin
         req_valid <= 1'b0;
         while (expected_limits.size() != 0) @(negedge clock);
         repeat (400) @(negedge clock);
      end
   endtask

   function automatic req_type make_request(command_type c, logic signed [31:0] pos);
      req_type r;
      begin
         r.command = c;
         r.position = pos;
         r.velocity = $urandom;
         r.accel = $urandom;
         r.tracking_error = ($urandom_range(3) == 0) ? $urandom : $urandom_range(30000);
         r.feed_ratio = 18'($urandom_range(18'h3FFFF));
         return r;
      end
   endfunction

   function automatic logic signed [31:0] pos_near();
      int b;
      begin
         b = $urandom_range(5);
         return cfg_min_pos + b * int'(cfg_width) + $urandom_range(cfg_width);
      end
   endfunction

   task automatic test_directed();
      req_type r;
      begin
         r = '0;
         r.command = CMD_QUERY;
         send_request(r);
         r = '1;
         r.command = CMD_ADD;
         send_request(r);
         r.position = 32'sh8000_0000;
         r.tracking_error = 0;
         r.feed_ratio = 0;
         send_request(r);
         r.velocity = 0;
         r.accel = 0;
         send_request(r);
         r.command = CMD_QUERY;
         r.position = 32'sh7FFF_FFFF;
         send_request(r);
         r.position = 32'sh8000_0000;
         send_request(r);
         r.command = CMD_NONE;
         send_request(r);
         for (int i = 0; i < 11; i++) send_request(make_request(CMD_ADD, 100));
         send_request(make_request(CMD_QUERY, 100));
         send_request(make_request(CMD_CLEAR, 0));
         send_request(make_request(CMD_QUERY, 100));
         drain();
      end
   endtask

   task automatic test_config_edges();
      begin
         // zero bins, zero width, zero threshold, full margin
         write_csr(CSR_BINS_IN_USE, 0);
         send_request(make_request(CMD_ADD, 5));
         send_request(make_request(CMD_QUERY, 5));
         drain();
         write_csr(CSR_BINS_IN_USE, 9'h1FF);
         write_csr(CSR_BIN_WIDTH, 0);
         write_csr(CSR_ERROR_THRESH, 0);
         write_csr(CSR_SAFETY_MARGIN, 16'hFFFF);
         write_csr(CSR_MIN_SAMPLES, 0);
         write_csr(CSR_MIN_POSITION, 32'h8000_0000);
         write_csr(CSR_DEFAULT_MAX_V, 32'hFFFF_FFFF);
         write_csr(CSR_DEFAULT_MAX_A, 0);
         for (int i = 0; i < 6; i++) begin
            send_request(make_request(CMD_ADD, 32'sh8000_0000 + $urandom_range(300)));
            send_request(make_request(CMD_QUERY, 32'sh8000_0000 + $urandom_range(300)));
         end
         drain();
      end
   endtask

   task automatic test_random(int n);
      command_type c;
      int          k;
      begin
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            c = (k < 60) ? CMD_ADD : (k < 95) ? CMD_QUERY : (k < 97) ? CMD_NONE : CMD_CLEAR;
            send_request(make_request(c, ($urandom_range(9) == 0) ? $urandom : pos_near()));
         end
         drain();
      end
   endtask

   task automatic test_backpressure();
      begin
         rsp_hold = 1'b1;
         for (int i = 0; i < 8; i++) send_request(make_request(CMD_QUERY, pos_near()));
         drain();
      end
   endtask

   task automatic randomize_config(bit extreme);
      begin
         write_csr(CSR_MIN_POSITION, extreme ? 32'h7FFF_0000 : $urandom_range(2000) - 1000);
         write_csr(CSR_BIN_WIDTH, extreme ? 24'hFFFFFF : $urandom_range(1, 500));
         write_csr(CSR_BINS_IN_USE, extreme ? 1 : $urandom_range(1, 300));
         write_csr(CSR_MIN_SAMPLES, extreme ? 16'hFFFF : $urandom_range(6));
         write_csr(CSR_SAFETY_MARGIN, $urandom_range(16'hFFFF));
         write_csr(CSR_ERROR_THRESH, extreme ? 32'hFFFF_FFFF : $urandom_range(1, 20000));
         write_csr(CSR_DEFAULT_MAX_V, $urandom);
         write_csr(CSR_DEFAULT_MAX_A, $urandom);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type e;
         if (expected_limits.size() == 0) begin
            $error("response with no query outstanding");
            fail_count++;
         end else begin
            e = expected_limits.pop_front();
            if (rsp_data.suggested_velocity !== e.suggested_velocity) begin
               $error("suggested_velocity exp %0d got %0d",
                      e.suggested_velocity, rsp_data.suggested_velocity);
               fail_count++;
            end
            if (rsp_data.suggested_accel !== e.suggested_accel) begin
               $error("suggested_accel exp %0d got %0d",
                      e.suggested_accel, rsp_data.suggested_accel);
               fail_count++;
            end
            if (rsp_data.limit_reason !== e.limit_reason) begin
               $error("limit_reason exp %0d got %0d", e.limit_reason, rsp_data.limit_reason);
               fail_count++;
            end
            if (rsp_data.bin_samples !== e.bin_samples) begin
               $error("bin_samples exp %0d got %0d", e.bin_samples, rsp_data.bin_samples);
               fail_count++;
            end
            if (rsp_data.bin_max_velocity !== e.bin_max_velocity) begin
               $error("bin_max_velocity exp %0d got %0d",
                      e.bin_max_velocity, rsp_data.bin_max_velocity);
               fail_count++;
            end
            if (rsp_data.bin_max_accel !== e.bin_max_accel) begin
               $error("bin_max_accel exp %0d got %0d",
                      e.bin_max_accel, rsp_data.bin_max_accel);
               fail_count++;
            end
            if (rsp_data.bin_max_error !== e.bin_max_error) begin
               $error("bin_max_error exp %0d got %0d",
                      e.bin_max_error, rsp_data.bin_max_error);
               fail_count++;
            end
            if (rsp_data.bin_mean_error !== e.bin_mean_error) begin
               $error("bin_mean_error exp %0d got %0d",
                      e.bin_mean_error, rsp_data.bin_mean_error);
               fail_count++;
            end
            if (rsp_data.bin_mean_ratio !== e.bin_mean_ratio) begin
               $error("bin_mean_ratio exp %0d got %0d",
                      e.bin_mean_ratio, rsp_data.bin_mean_ratio);
               fail_count++;
            end
         end
      end
   end

   // receiver readiness, with one long hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
         repeat (1500) @(negedge clock);
         rsp_hold = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      cfg_min_pos = RST_MIN_POSITION;
      cfg_width = RST_BIN_WIDTH;
      cfg_bins = RST_BINS_IN_USE;
      cfg_min_samples = RST_MIN_SAMPLES;
      cfg_margin = RST_SAFETY_MARGIN;
      cfg_err_thresh = RST_ERROR_THRESH;
      cfg_def_v = RST_DEFAULT_MAX_V;
      cfg_def_a = RST_DEFAULT_MAX_A;
      clear_stats();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_edges();
      randomize_config(1'b0);
      test_random(200);
      idle_pct = 0;
      test_random(100);
      idle_pct = 21;
      test_backpressure();
      randomize_config(1'b1);
      test_random(60);
      randomize_config(1'b0);
      test_random(300);
      $display("covered %0d adds and %0d queries over several register settings",
               add_count, query_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/bmls_pkg.sv
rtl/core/binned_motion_limit_stats.sv
rtl/core/bmls_checker.sv
bench/binned_motion_limit_stats_tb.sv
